@@ rtl/fmr_pkg.sv @@
// Package for the Fresnel mirror reflectance unit.
// Holds the register index codes and the fixed field widths; no dependencies.
`default_nettype none
package fmr_pkg;
  // Width of every vector component, signed Q2.14.
  localparam int unsigned VectorBits = 16;
  localparam int unsigned IndexBits = 16;
  localparam int unsigned KrBits    = 16;
  localparam int unsigned WeightBits = 16;
  localparam int unsigned CfgAddrBits = 1;
  localparam int unsigned CfgDataBits = 16;
  localparam logic [IndexBits-1:0] IndexReset = 16'd4096;

  // Configuration register indexes.
  typedef enum logic [CfgAddrBits-1:0] {
    CFG_INDEX_INSIDE  = 1'b0,
    CFG_INDEX_OUTSIDE = 1'b1
  } cfg_reg_e;

  // Width of the Fresnel cosine, unsigned Q.15 up to 1.0.
  localparam int unsigned CosBits = 16;
  // Width of the radicand A*A*2^30 (A up to 16 bits).
  localparam int unsigned RadBits = 62;
  localparam int unsigned RootBits = RadBits / 2;
  localparam int unsigned RatioBits = 17;
endpackage
`default_nettype wire

@@ rtl/fmr_if.sv @@
// Valid/ready stream interface used by every channel of the unit.
// Payload type is a parameter; no package dependency.
`default_nettype none
interface fmr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/fmr_isqrt_stage.sv @@
// One registered stage of the restoring integer square root (two root bits).
// Uses fmr_pkg for the radicand width.
`default_nettype none
module fmr_isqrt_stage #(
  parameter int unsigned Step = 0,
  parameter int unsigned PW = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic [fmr_pkg::RadBits-1:0]    rem_i,
  input  wire logic [fmr_pkg::RootBits-1:0]   root_i,
  input  wire logic [PW-1:0]                  pass_i,
  output logic [fmr_pkg::RadBits-1:0]         rem_o,
  output logic [fmr_pkg::RootBits-1:0]        root_o,
  output logic [PW-1:0]                       pass_o
);
  localparam int unsigned RB = fmr_pkg::RadBits;
  localparam int unsigned QB = fmr_pkg::RootBits;
  logic [RB-1:0] rem_d;
  logic [QB-1:0] root_d;

  // Two digits of the root per stage, each a trial subtract.
  // With an odd root width the last stage settles only one digit.
  always_comb begin
    logic [RB-1:0] r;
    logic [QB-1:0] q;
    logic [RB:0]   trial;
    int unsigned   k;
    r = rem_i;
    q = root_i;
    for (int j = 0; j < 2; j++) begin
      if (Step * 2 + j < QB) begin
        k = QB - 1 - (Step * 2 + j);
        trial = {1'b0, r} - (({{(RB+1-QB){1'b0}}, q} << (k + 1)) |
                ({{RB{1'b0}}, 1'b1} << (2 * k)));
        if (!trial[RB]) begin
          r = trial[RB-1:0];
          q = q | (QB'(1) << k);
        end
      end
    end
    rem_d = r;
    root_d = q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
      pass_o <= pass_i;
    end
  end
endmodule
`default_nettype wire

@@ rtl/fmr_div_stage.sv @@
// One registered stage of a restoring divider producing a few quotient bits.
// No package dependency.
`default_nettype none
module fmr_div_stage #(
  parameter int unsigned NW = 17,
  parameter int unsigned DW = 32,
  parameter int unsigned Bits = 4,
  parameter int unsigned PW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [NW-1:0] quo_i,
  input  wire logic [PW-1:0] pass_i,
  output logic [DW-1:0]      den_o,
  output logic [DW-1:0]      rem_o,
  output logic [NW-1:0]      num_o,
  output logic [NW-1:0]      quo_o,
  output logic [PW-1:0]      pass_o
);
  logic [DW-1:0] rem_d;
  logic [NW-1:0] num_d, quo_d;

  // Shift in one numerator bit at a time and try the subtract.
  always_comb begin
    logic [DW:0] t;
    rem_d = rem_i;
    num_d = num_i;
    quo_d = quo_i;
    for (int j = 0; j < int'(Bits); j++) begin
      t = {rem_d, num_d[NW-1]};
      num_d = num_d << 1;
      if (t >= {1'b0, den_i}) begin
        t = t - {1'b0, den_i};
        quo_d = {quo_d[NW-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[NW-2:0], 1'b0};
      end
      rem_d = t[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o  <= den_i;
      rem_o  <= rem_d;
      num_o  <= num_d;
      quo_o  <= quo_d;
      pass_o <= pass_i;
    end
  end
endmodule
`default_nettype wire

@@ rtl/fresnel_mirror_reflectance_unit.sv @@
// Fresnel mirror reflectance unit: top level.
// Fully pipelined; one request accepted per cycle while the output is not
// stalled; the latency is set by the square root and the three dividers,
// each a chain of registered stages.
// A stall of the output freezes the whole pipe; nothing is lost or repeated.
// Reset clears the valid bits and sets both index registers to 1.0.
`default_nettype none
module fresnel_mirror_reflectance_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fmr_stream_if.sink   in_if,
  fmr_stream_if.source out_if,
  fmr_stream_if.sink   cfg_if
);
  localparam int unsigned VB = fmr_pkg::VectorBits;
  localparam int unsigned FRAC = VB - 2;
  localparam int unsigned PB = 2 * VB;          // product width
  localparam int unsigned DB = FRAC + 4;        // saturated dot width (signed)
  localparam int unsigned RB = fmr_pkg::RadBits;
  localparam int unsigned QB = fmr_pkg::RootBits;
  localparam int unsigned SQ = QB / 2 + QB % 2; // root stages
  localparam int unsigned RW = fmr_pkg::RatioBits;
  localparam int unsigned D1 = 64;              // divider widths
  localparam int unsigned RQ = 17;              // ratio quotient bits
  localparam int unsigned DVS = 4;              // ratio divider stages
  localparam int unsigned WN = 16 + FRAC;       // weight numerator bits
  localparam int unsigned WS = (WN + 3) / 4;    // weight divider stages
  localparam int unsigned WNP = WS * 4;
  localparam int unsigned KB = fmr_pkg::KrBits;

  // Items travel as one flat side record; fields are picked by name.
  typedef struct packed {
    logic [VB-1:0] rx, ry, rz;
    logic [DB:0]   cabs;
    logic          tir;
  } side_t;
  localparam int unsigned SW = $bits(side_t);

  // ---------------- pipeline control ----------------
  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || out_if.ready;
  assign in_if.ready = en;
  localparam int unsigned LAT = 6 + SQ + 2 + DVS + 2 + WS;
  logic [LAT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_if.valid};
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[LAT-1];
    end
  end
  assign out_if.valid = out_valid_q;

  // ---------------- configuration ----------------
  logic [15:0] ix_in_q, ix_out_q;
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ix_in_q  <= fmr_pkg::IndexReset;
      ix_out_q <= fmr_pkg::IndexReset;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.index)
        fmr_pkg::CFG_INDEX_INSIDE:  ix_in_q  <= cfg_if.data.value;
        fmr_pkg::CFG_INDEX_OUTSIDE: ix_out_q <= cfg_if.data.value;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: products for n.v and n.d ----------------
  logic signed [VB-1:0] n1_q [3];
  logic signed [VB-1:0] v1_q [3];
  logic signed [PB-1:0] pv1_q [3], pd1_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q[0] <= in_if.data.normal_x; n1_q[1] <= in_if.data.normal_y;
      n1_q[2] <= in_if.data.normal_z;
      v1_q[0] <= in_if.data.view_x; v1_q[1] <= in_if.data.view_y;
      v1_q[2] <= in_if.data.view_z;
      pv1_q[0] <= PB'($signed(in_if.data.normal_x) * $signed(in_if.data.view_x));
      pv1_q[1] <= PB'($signed(in_if.data.normal_y) * $signed(in_if.data.view_y));
      pv1_q[2] <= PB'($signed(in_if.data.normal_z) * $signed(in_if.data.view_z));
      pd1_q[0] <= PB'($signed(in_if.data.normal_x) * $signed(in_if.data.ray_dir_x));
      pd1_q[1] <= PB'($signed(in_if.data.normal_y) * $signed(in_if.data.ray_dir_y));
      pd1_q[2] <= PB'($signed(in_if.data.normal_z) * $signed(in_if.data.ray_dir_z));
    end
  end

  // Dot product sum and saturation (floor shifts are arithmetic shifts).
  function automatic logic signed [DB-1:0] dot_sat(input logic signed [PB-1:0] p0,
      input logic signed [PB-1:0] p1, input logic signed [PB-1:0] p2);
    logic signed [PB+1:0] s;
    logic signed [PB+1:0] lim;
    s = (PB+2)'(p0 >>> 2) + (PB+2)'(p1 >>> 2) + (PB+2)'(p2 >>> 2);
    s = s >>> (FRAC - 2);
    lim = (PB+2)'((64'sd1 <<< (FRAC + 2)) - 1);
    if (s > lim) s = lim;
    if (s < -lim) s = -lim;
    return s[DB-1:0];
  endfunction

  // ---------------- stage 2: dot products ----------------
  logic signed [VB-1:0] n2_q [3], v2_q [3];
  logic signed [DB-1:0] dnv2_q, dnd2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      n2_q <= n1_q;
      v2_q <= v1_q;
      dnv2_q <= dot_sat(pv1_q[0], pv1_q[1], pv1_q[2]);
      dnd2_q <= dot_sat(pd1_q[0], pd1_q[1], pd1_q[2]);
    end
  end

  // ---------------- stage 3: reflection products, cosine ----------------
  logic signed [VB-1:0] n3_q [3], v3_q [3];
  logic signed [VB+DB-1:0] pr3_q [3];
  logic [15:0] a3_q, b3_q;
  logic [fmr_pkg::CosBits-1:0] c3_q;
  always_ff @(posedge clk_i) begin
    logic [DB-1:0] cm;
    logic [DB+15:0] cx;
    if (en) begin
      n3_q <= n2_q;
      v3_q <= v2_q;
      for (int i = 0; i < 3; i++) pr3_q[i] <= (VB+DB)'(n2_q[i] * dnv2_q);
      if (dnd2_q > 0) begin
        a3_q <= ix_out_q; b3_q <= ix_in_q;
      end else begin
        a3_q <= ix_in_q; b3_q <= ix_out_q;
      end
      cm = dnd2_q[DB-1] ? DB'(-dnd2_q) : DB'(dnd2_q);
      if (cm > (DB'(1) << FRAC)) cm = DB'(1) << FRAC;
      cx = (DB+16)'(cm) << 15;
      c3_q <= fmr_pkg::CosBits'(cx >> FRAC);
    end
  end

  // ---------------- stage 4: reflected vector, Fresnel squares ----------------
  logic signed [VB-1:0] n4_q [3], r4_q [3];
  logic [31:0] aa4_q, bb4_q, cc4_q;
  logic [15:0] b4_q, c4_q;
  always_ff @(posedge clk_i) begin
    logic signed [VB+DB:0] t;
    if (en) begin
      n4_q <= n3_q;
      for (int i = 0; i < 3; i++) begin
        t = (VB+DB+1)'(pr3_q[i] >>> (FRAC - 1)) - (VB+DB+1)'(v3_q[i]);
        if (t > (VB+DB+1)'((64'sd1 <<< (VB-1)) - 1)) t = (VB+DB+1)'((64'sd1 <<< (VB-1)) - 1);
        if (t < -(VB+DB+1)'(64'sd1 <<< (VB-1))) t = -(VB+DB+1)'(64'sd1 <<< (VB-1));
        r4_q[i] <= t[VB-1:0];
      end
      aa4_q <= a3_q * a3_q;
      bb4_q <= b3_q * b3_q;
      cc4_q <= c3_q * c3_q;
      b4_q <= b3_q;
      c4_q <= c3_q;
    end
  end

  // ---------------- stage 5: n.r products, y = B*B*(2^30 - c*c) ----------------
  logic signed [VB-1:0] r5_q [3];
  logic signed [PB-1:0] pr5_q [3];
  logic [RB-1:0] x5_q, y5_q;
  logic [31:0] aa5_q;
  logic [15:0] b5_q, c5_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      r5_q <= r4_q;
      for (int i = 0; i < 3; i++) pr5_q[i] <= PB'(n4_q[i] * r4_q[i]);
      x5_q <= RB'({aa4_q, 30'd0});
      y5_q <= RB'(bb4_q * (31'd1 << 30) - RB'(bb4_q) * RB'(cc4_q));
      aa5_q <= aa4_q; b5_q <= b4_q; c5_q <= c4_q;
    end
  end

  // ---------------- stage 6: n.r, radicand, TIR ----------------
  side_t s6;
  logic [RB-1:0] rad6_q;
  logic [31:0] aa6_q;
  logic [15:0] b6_q, c6_q;
  side_t side6_q;
  always_comb begin
    logic signed [DB-1:0] cr;
    cr = dot_sat(pr5_q[0], pr5_q[1], pr5_q[2]);
    s6.rx = r5_q[0]; s6.ry = r5_q[1]; s6.rz = r5_q[2];
    s6.cabs = cr[DB-1] ? (DB+1)'(-cr) : (DB+1)'(cr);
    s6.tir = x5_q < y5_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      side6_q <= s6;
      rad6_q <= s6.tir ? '0 : x5_q - y5_q;
      aa6_q <= aa5_q; b6_q <= b5_q; c6_q <= c5_q;
    end
  end

  // ---------------- square root pipeline ----------------
  localparam int unsigned PQ = SW + 32 + 32;
  logic [RB-1:0] srem [SQ+1];
  logic [QB-1:0] sroot [SQ+1];
  logic [PQ-1:0] spass [SQ+1];
  assign srem[0] = rad6_q;
  assign sroot[0] = '0;
  assign spass[0] = {side6_q, aa6_q, b6_q, c6_q};
  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    fmr_isqrt_stage #(.Step(g), .PW(PQ)) u_stage (
      .clk_i, .en_i(en), .rem_i(srem[g]), .root_i(sroot[g]), .pass_i(spass[g]),
      .rem_o(srem[g+1]), .root_o(sroot[g+1]), .pass_o(spass[g+1]));
  end

  // ---------------- ratio terms ----------------
  side_t side7;
  logic [31:0] aa7; logic [15:0] b7, c7;
  assign {side7, aa7, b7, c7} = spass[SQ];
  logic [47:0] p1_q, q1_q;
  logic [31:0] p2_q, q2_q;
  side_t side8_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= aa7 * c7;
      q1_q <= 48'(b7 * sroot[SQ]);
      p2_q <= b7 * c7;
      q2_q <= 32'(sroot[SQ]);
      side8_q <= side7;
    end
  end
  logic [D1-1:0] n1d_q, d1d_q, n2d_q, d2d_q;
  side_t side9_q;
  logic z1_q, z2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      n1d_q <= D1'(p1_q > q1_q ? p1_q - q1_q : q1_q - p1_q);
      d1d_q <= D1'(p1_q) + D1'(q1_q);
      n2d_q <= D1'(p2_q > q2_q ? p2_q - q2_q : q2_q - p2_q);
      d2d_q <= D1'(p2_q) + D1'(q2_q);
      z1_q <= (p1_q == '0) && (q1_q == '0);
      z2_q <= (p2_q == '0) && (q2_q == '0);
      side9_q <= side8_q;
    end
  end

  // Two dividers in lockstep. The numerator never exceeds the denominator,
  // so the 2^16 quotient bit is set only when they are equal (one term zero);
  // that case is settled up front with a zero remainder. Otherwise the
  // numerator seeds the remainder and sixteen steps give num*2^16/den.
  localparam int unsigned RPW = SW + 2;
  logic [D1-1:0] ad_den [DVS+1], ad_rem [DVS+1];
  logic [D1-1:0] bd_den [DVS+1], bd_rem [DVS+1];
  logic [RQ-1:0] ad_num [DVS+1], ad_quo [DVS+1], bd_num [DVS+1], bd_quo [DVS+1];
  logic [RPW-1:0] ad_pass [DVS+1], bd_pass [DVS+1];
  logic eq1, eq2;
  assign eq1 = n1d_q == d1d_q;
  assign eq2 = n2d_q == d2d_q;
  assign ad_den[0] = d1d_q; assign ad_rem[0] = eq1 ? '0 : n1d_q;
  assign bd_den[0] = d2d_q; assign bd_rem[0] = eq2 ? '0 : n2d_q;
  assign ad_num[0] = '0; assign ad_quo[0] = RQ'(eq1);
  assign bd_num[0] = '0; assign bd_quo[0] = RQ'(eq2);
  assign ad_pass[0] = {side9_q, z1_q, z2_q};
  assign bd_pass[0] = '0;
  for (genvar g = 0; g < DVS; g++) begin : g_rdiv
    fmr_div_stage #(.NW(RQ), .DW(D1), .Bits(4), .PW(RPW)) u_a (
      .clk_i, .en_i(en), .den_i(ad_den[g]), .rem_i(ad_rem[g]), .num_i(ad_num[g]),
      .quo_i(ad_quo[g]), .pass_i(ad_pass[g]), .den_o(ad_den[g+1]), .rem_o(ad_rem[g+1]),
      .num_o(ad_num[g+1]), .quo_o(ad_quo[g+1]), .pass_o(ad_pass[g+1]));
    fmr_div_stage #(.NW(RQ), .DW(D1), .Bits(4), .PW(RPW)) u_b (
      .clk_i, .en_i(en), .den_i(bd_den[g]), .rem_i(bd_rem[g]), .num_i(bd_num[g]),
      .quo_i(bd_quo[g]), .pass_i(bd_pass[g]), .den_o(bd_den[g+1]), .rem_o(bd_rem[g+1]),
      .num_o(bd_num[g+1]), .quo_o(bd_quo[g+1]), .pass_o(bd_pass[g+1]));
  end

  // ---------------- kr ----------------
  side_t sideR; logic zr1, zr2;
  assign {sideR, zr1, zr2} = ad_pass[DVS];
  logic [RW-1:0] ra, rb;
  assign ra = zr1 ? RW'(65536) : ad_quo[DVS];
  assign rb = zr2 ? RW'(65536) : bd_quo[DVS];
  logic [33:0] sa_q, sb_q;
  side_t sideS_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q <= ra * ra;
      sb_q <= rb * rb;
      sideS_q <= sideR;
    end
  end
  logic [KB-1:0] krT_q;
  side_t sideT_q;
  always_ff @(posedge clk_i) begin
    logic [35:0] s;
    if (en) begin
      s = 36'(sa_q) + 36'(sb_q) + 36'(1 << 17);
      krT_q <= sideS_q.tir ? KB'(32768) : KB'(s >> 18);
      sideT_q <= sideS_q;
    end
  end

  // ---------------- weight divider ----------------
  localparam int unsigned WPW = SW + KB;
  localparam int unsigned WD = DB + 1;
  logic [WD-1:0] wd_den [WS+1], wd_rem [WS+1];
  logic [WNP-1:0] wd_num [WS+1], wd_quo [WS+1];
  logic [WPW-1:0] wd_pass [WS+1];
  assign wd_den[0] = sideT_q.cabs;
  assign wd_rem[0] = '0;
  assign wd_num[0] = WNP'(krT_q) << (FRAC - 3);
  assign wd_quo[0] = '0;
  assign wd_pass[0] = {sideT_q, krT_q};
  for (genvar g = 0; g < WS; g++) begin : g_wdiv
    fmr_div_stage #(.NW(WNP), .DW(WD), .Bits(4), .PW(WPW)) u_w (
      .clk_i, .en_i(en), .den_i(wd_den[g]), .rem_i(wd_rem[g]), .num_i(wd_num[g]),
      .quo_i(wd_quo[g]), .pass_i(wd_pass[g]), .den_o(wd_den[g+1]), .rem_o(wd_rem[g+1]),
      .num_o(wd_num[g+1]), .quo_o(wd_quo[g+1]), .pass_o(wd_pass[g+1]));
  end

  // ---------------- output register ----------------
  side_t sideW; logic [KB-1:0] krW;
  assign {sideW, krW} = wd_pass[WS];
  always_ff @(posedge clk_i) begin
    logic zc, big;
    if (en) begin
      zc = sideW.cabs == '0;
      big = (wd_quo[WS] >> 16) != '0;
      out_if.data.refl_x <= sideW.rx;
      out_if.data.refl_y <= sideW.ry;
      out_if.data.refl_z <= sideW.rz;
      out_if.data.reflectance <= krW;
      out_if.data.weight <= (zc || big) ? 16'hFFFF : wd_quo[WS][15:0];
      out_if.data.total_internal <= sideW.tir;
      out_if.data.weight_saturated <= zc || big;
    end
  end
endmodule
`default_nettype wire

@@ rtl/fmr_checker.sv @@
// Port-level checker for the Fresnel mirror reflectance unit, with its bind.
// No package dependency.
`default_nettype none
module fmr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic [15:0] reflectance_i,
  input wire logic [15:0] weight_i,
  input wire logic total_internal_i,
  input wire logic weight_saturated_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  a_kr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> reflectance_i <= 16'd32768) else $error("reflectance out of range");
  a_tir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && total_internal_i |-> reflectance_i == 16'd32768)
    else $error("tir value");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && weight_saturated_i |-> weight_i == 16'hFFFF) else $error("sat weight");
endmodule

bind fresnel_mirror_reflectance_unit fmr_checker u_fmr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .reflectance_i(out_if.data.reflectance), .weight_i(out_if.data.weight),
  .total_internal_i(out_if.data.total_internal),
  .weight_saturated_i(out_if.data.weight_saturated));
`default_nettype wire

@@ test/fmr_tb_types.sv @@
// Request, result and register-write payload types shared by the bench files.
// Depends on fmr_pkg for the register index codes and field widths.
package fmr_tb_types;
  import fmr_pkg::*;

  localparam int unsigned VecBits = VectorBits;

  // One request: surface normal, incident ray and view direction, Q2.14 each.
  typedef struct packed {
    logic signed [VecBits-1:0] normal_x;
    logic signed [VecBits-1:0] normal_y;
    logic signed [VecBits-1:0] normal_z;
    logic signed [VecBits-1:0] ray_dir_x;
    logic signed [VecBits-1:0] ray_dir_y;
    logic signed [VecBits-1:0] ray_dir_z;
    logic signed [VecBits-1:0] view_x;
    logic signed [VecBits-1:0] view_y;
    logic signed [VecBits-1:0] view_z;
  } shade_req_t;

  // One result: reflected direction, reflectance, weight and two flags.
  typedef struct packed {
    logic signed [VecBits-1:0] refl_x;
    logic signed [VecBits-1:0] refl_y;
    logic signed [VecBits-1:0] refl_z;
    logic [KrBits-1:0]         reflectance;
    logic [WeightBits-1:0]     weight;
    logic                      total_internal;
    logic                      weight_saturated;
  } shade_rsp_t;

  // One register write.
  typedef struct packed {
    cfg_reg_e               index;
    logic [CfgDataBits-1:0] value;
  } index_wr_t;
endpackage

@@ test/reflectance_checker.sv @@
// Checker for the Fresnel mirror reflectance unit: watches the three channels,
// predicts every result and compares it. Depends on fmr_pkg, fmr_tb_types, fmr_stream_if.
module reflectance_checker
  import fmr_pkg::*;
  import fmr_tb_types::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  fmr_stream_if in_mon,
  fmr_stream_if out_mon,
  fmr_stream_if cfg_mon,
  output int    fail_count_o,
  output int    pending_o,
  output int    result_count_o,
  output int    tir_count_o,
  output int    wsat_count_o
);
  localparam int Frac = VecBits - 2;
  localparam longint DotLim = (64'sd1 <<< (Frac + 2)) - 1;
  localparam longint VecMax = (64'sd1 <<< (VecBits - 1)) - 1;
  localparam longint VecMin = -(64'sd1 <<< (VecBits - 1));

  logic [15:0] idx_in_q, idx_out_q;
  shade_rsp_t  expected_rsp_q[$];

  // Dot product of two vectors with the unit's truncation and saturation.
  function automatic longint dot_q14(longint p[3], longint q[3]);
    longint s;
    s = 0;
    for (int i = 0; i < 3; i++) s += (p[i] * q[i]) >>> 2;
    s = s >>> (Frac - 2);
    if (s > DotLim) s = DotLim;
    if (s < -DotLim) s = -DotLim;
    return s;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] x);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Ratio |p-q|/(p+q) in Q.16; a zero denominator counts as one.
  function automatic bit [63:0] ratio_q16(bit [63:0] p, bit [63:0] q);
    bit [63:0] num, den;
    num = (p > q) ? p - q : q - p;
    den = p + q;
    if (den == 0) return 64'd65536;
    return (num << 16) / den;
  endfunction

  // Unpolarized dielectric reflectance in Q1.15, with the total internal flag.
  function automatic bit [63:0] fresnel_kr(bit [63:0] a, bit [63:0] b, bit [63:0] c,
                                           output bit tir);
    bit [63:0] x, y, u, r1, r2;
    x = (a * a) << 30;
    y = b * b * ((64'd1 << 30) - c * c);
    tir = (x < y);
    if (tir) return 64'd32768;
    u = int_sqrt(x - y);
    r1 = ratio_q16(a * a * c, b * u);
    r2 = ratio_q16(b * c, u);
    return (r1 * r1 + r2 * r2 + (64'd1 << 17)) >> 18;
  endfunction

  function automatic shade_rsp_t predict_shade(shade_req_t q);
    longint n[3], d[3], v[3], r[3];
    longint dnv, dnd, cr, t;
    bit [63:0] a, b, cmag, kr, cabs, w;
    bit tir, wsat;
    shade_rsp_t rsp;
    n = '{q.normal_x, q.normal_y, q.normal_z};
    d = '{q.ray_dir_x, q.ray_dir_y, q.ray_dir_z};
    v = '{q.view_x, q.view_y, q.view_z};
    // Mirror reflection of the view direction about the normal.
    dnv = dot_q14(n, v);
    for (int i = 0; i < 3; i++) begin
      t = -v[i] + ((n[i] * dnv) >>> (Frac - 1));
      if (t > VecMax) t = VecMax;
      if (t < VecMin) t = VecMin;
      r[i] = t;
    end
    // A ray from the back side swaps the indices.
    dnd = dot_q14(n, d);
    a = (dnd > 0) ? idx_out_q : idx_in_q;
    b = (dnd > 0) ? idx_in_q : idx_out_q;
    cmag = (dnd < 0) ? -dnd : dnd;
    if (cmag > (64'd1 << Frac)) cmag = 64'd1 << Frac;
    kr = fresnel_kr(a, b, cmag << (15 - Frac), tir);
    // Weight is kr over the reflected cosine, saturated.
    cr = dot_q14(n, r);
    cabs = (cr < 0) ? -cr : cr;
    wsat = 0;
    if (cabs == 0) begin
      w = 65535;
      wsat = 1;
    end else begin
      w = (kr << (Frac - 3)) / cabs;
      if (w > 65535) begin
        w = 65535;
        wsat = 1;
      end
    end
    rsp.refl_x = VecBits'(r[0]);
    rsp.refl_y = VecBits'(r[1]);
    rsp.refl_z = VecBits'(r[2]);
    rsp.reflectance = kr[15:0];
    rsp.weight = w[15:0];
    rsp.total_internal = tir;
    rsp.weight_saturated = wsat;
    return rsp;
  endfunction

  assign pending_o = expected_rsp_q.size();

  // Track register writes, predict on each accepted request, check each result.
  always @(posedge clk_i or negedge rst_ni) begin
    shade_rsp_t got, exp_rsp;
    index_wr_t wr;
    if (!rst_ni) begin
      idx_in_q <= IndexReset;
      idx_out_q <= IndexReset;
      fail_count_o <= 0;
      result_count_o <= 0;
      tir_count_o <= 0;
      wsat_count_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        wr = cfg_mon.data;
        if (wr.index == CFG_INDEX_INSIDE) idx_in_q <= wr.value;
        else idx_out_q <= wr.value;
      end
      if (in_mon.valid && in_mon.ready) expected_rsp_q.push_back(predict_shade(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        result_count_o <= result_count_o + 1;
        if (expected_rsp_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          tir_count_o <= tir_count_o + exp_rsp.total_internal;
          wsat_count_o <= wsat_count_o + exp_rsp.weight_saturated;
          if (got !== exp_rsp) begin
            fail_count_o <= fail_count_o + 1;
            if (got.refl_x !== exp_rsp.refl_x)
              $error("refl_x expected %0d got %0d", exp_rsp.refl_x, got.refl_x);
            if (got.refl_y !== exp_rsp.refl_y)
              $error("refl_y expected %0d got %0d", exp_rsp.refl_y, got.refl_y);
            if (got.refl_z !== exp_rsp.refl_z)
              $error("refl_z expected %0d got %0d", exp_rsp.refl_z, got.refl_z);
            if (got.reflectance !== exp_rsp.reflectance)
              $error("reflectance expected %0d got %0d", exp_rsp.reflectance,
                     got.reflectance);
            if (got.weight !== exp_rsp.weight)
              $error("weight expected %0d got %0d", exp_rsp.weight, got.weight);
            if (got.total_internal !== exp_rsp.total_internal)
              $error("total_internal expected %0b got %0b", exp_rsp.total_internal,
                     got.total_internal);
            if (got.weight_saturated !== exp_rsp.weight_saturated)
              $error("weight_saturated expected %0b got %0b",
                     exp_rsp.weight_saturated, got.weight_saturated);
          end
        end
      end
    end
  end
endmodule

@@ test/testbench.sv @@
// Top of the bench: drives requests and index writes into the reflectance unit
// and gives the verdict. Depends on fmr_pkg, fmr_tb_types, fmr_stream_if, reflectance_checker.
module testbench;
  import fmr_pkg::*;
  import fmr_tb_types::*;

  localparam int IdleLimit = 5000;
  localparam int NumPhases = 8;
  localparam int ItemsPerPhase = 190;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, result_count, tir_count, wsat_count;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 0;
  int   req_count = 0;

  fmr_stream_if #(.payload_t(shade_req_t)) in_if ();
  fmr_stream_if #(.payload_t(shade_rsp_t)) out_if ();
  fmr_stream_if #(.payload_t(index_wr_t))  cfg_if ();

  fresnel_mirror_reflectance_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  reflectance_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .cfg_mon        (cfg_if),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .tir_count_o    (tir_count),
    .wsat_count_o   (wsat_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off when requested.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no transfer on any channel.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready) || hold_off)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout after %0d idle cycles", IdleLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Send one request, with random gaps ahead of it; returns at a falling edge.
  task automatic send_req(shade_req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= q;
    do @(posedge clk_i); while (!in_if.ready);
    req_count++;
    @(negedge clk_i);
  endtask

  // Wait until every result is back, then let the pipe drain.
  task automatic drain_pipe();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_index(cfg_reg_e addr, logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: addr, value: value};
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Roughly unit vector in Q2.14, pointing in a random direction.
  function automatic void unit_vec(output logic signed [15:0] x, y, z);
    real a, b, c, m;
    a = $itor($urandom_range(2000)) - 1000.0;
    b = $itor($urandom_range(2000)) - 1000.0;
    c = $itor($urandom_range(2000)) - 1000.0;
    m = $sqrt(a * a + b * b + c * c);
    if (m < 1.0) begin
      a = 1000.0;
      m = 1000.0;
    end
    x = 16'($rtoi(a / m * 16384.0) + $signed($urandom_range(8)) - 4);
    y = 16'($rtoi(b / m * 16384.0) + $signed($urandom_range(8)) - 4);
    z = 16'($rtoi(c / m * 16384.0) + $signed($urandom_range(8)) - 4);
  endfunction

  // Mostly unit vectors with random content, the rest raw bit patterns.
  function automatic shade_req_t random_req();
    shade_req_t q;
    q = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    if ($urandom_range(99) < 75) begin
      unit_vec(q.normal_x, q.normal_y, q.normal_z);
      unit_vec(q.ray_dir_x, q.ray_dir_y, q.ray_dir_z);
      unit_vec(q.view_x, q.view_y, q.view_z);
      // Sometimes a view close to the surface, for very small cosines.
      if ($urandom_range(9) == 0) begin
        q.view_x = q.normal_y;
        q.view_y = -q.normal_x;
        q.view_z = 16'($signed($urandom_range(6)) - 3);
      end
    end
    return q;
  endfunction

  initial begin
    logic [15:0] ins[NumPhases], outs[NumPhases];
    shade_req_t q;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    ins = '{16'd4096, 16'd6144, 16'd4096, 16'd1, 16'd65535, 16'd65535, 16'd1, 16'd5461};
    outs = '{16'd4096, 16'd4096, 16'd6144, 16'd65535, 16'd1, 16'd65535, 16'd1, 16'd4096};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed requests at the reset indexes.
    q = '0;
    send_req(q);                       // zero normal: zero cosine, zero denominator
    q = {9{16'sh7fff}};
    send_req(q);
    q = {9{16'sh8000}};
    send_req(q);
    q = '0;
    q.normal_z = 16'sd16384; q.ray_dir_z = -16'sd16384; q.view_z = 16'sd16384;
    send_req(q);                       // head-on hit from the front
    q.ray_dir_z = 16'sd16384;
    send_req(q);                       // ray from the back side
    q.ray_dir_z = '0; q.ray_dir_x = 16'sd16384; q.view_z = '0; q.view_x = 16'sd16384;
    send_req(q);                       // grazing ray and view
    q.view_z = 16'sd1; q.view_x = 16'sd16383;
    send_req(q);                       // tiny reflected cosine saturates the weight
    q = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
          16'sh7fff, 16'sh8000, 16'sh7fff};
    send_req(q);                       // non-unit vectors
    for (int i = 0; i < 12; i++) send_req(random_req());
    drain_pipe();

    // Phases over index settings and idling modes.
    for (int p = 0; p < NumPhases; p++) begin
      write_index(CFG_INDEX_INSIDE, ins[p]);
      write_index(CFG_INDEX_OUTSIDE, outs[p]);
      send_idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 14 : 60) : 0;
      recv_stall_pct = (p % 4 == 2) ? 60 : ((p % 4 == 3) ? 14 : 0);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (p == 1 && i == 50) begin
          hold_off = 1'b1;
          fork
            begin
              repeat (400) @(negedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        if (p == 2 && i == 100) drain_pipe();
        send_req(random_req());
      end
      drain_pipe();
    end
    // Back to reset values.
    write_index(CFG_INDEX_INSIDE, IndexReset);
    write_index(CFG_INDEX_OUTSIDE, IndexReset);
    repeat (50) @(negedge clk_i);

    $display("Sent %0d requests over %0d index settings, %0d results checked",
             req_count, NumPhases + 1, result_count);
    $display("Total internal reflections %0d, saturated weights %0d", tir_count, wsat_count);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
